### design/xcpf_pkg.sv
// Shared types and constants of the packet framer.
// Used by every module of the framer but the payload store; depends on nothing.
`default_nettype none

package xcpf_pkg;

   // Item kinds on the request channel.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_IMAGE  = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // Trailer marker bytes.
   localparam logic [7:0] MARK_START = 8'hFF;
   localparam logic [7:0] MARK_DATA  = 8'h00;
   localparam logic [7:0] MARK_END   = 8'hCC;

   // Header bytes kept for the start frame.
   localparam logic [2:0] HEADER_MAX = 3'd5;

   // One frame to send: its index byte and its marker byte.
   typedef struct packed {
      logic [7:0] index;
      logic [7:0] marker;
   } xcpf_cmd_type;

endpackage

`default_nettype wire

### design/xcpf_store.sv
// Payload store: one write port, one registered read port, and a valid bit per entry.
// Uses nothing from the package; entries never written since the last clear read as zero.
`default_nettype none

module xcpf_store #(
   parameter int PAYLOAD_BYTES = 32,
   localparam int AW = $clog2(PAYLOAD_BYTES)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          clear,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0]               mem [PAYLOAD_BYTES];
   logic [PAYLOAD_BYTES-1:0] valid_ff;
   logic [PAYLOAD_BYTES-1:0] valid_in;
   logic [7:0]               rd_data_ff;

   always_comb begin
      valid_in = clear ? '0 : valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : 8'h00;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/xcpf_queue.sv
// Two-entry queue of frame commands between the front and the back.
// Depends on xcpf_pkg for the command type.
`default_nettype none

module xcpf_queue
   import xcpf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire xcpf_cmd_type push_cmd,
   input  wire logic         pop,
   output xcpf_cmd_type      head_cmd,
   output logic              empty,
   output logic              full
);

   xcpf_cmd_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);

endmodule

`default_nettype wire

### design/xcpf_front.sv
// Front end: accepts request items, keeps header, fill and index state, writes the
// payload store and queues frame commands. Depends on xcpf_pkg.
`default_nettype none

module xcpf_front
   import xcpf_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 32,
   localparam int AW = $clog2(PAYLOAD_BYTES),
   localparam int FW = $clog2(PAYLOAD_BYTES + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [1:0]    req_kind,
   input  wire logic [7:0]    req_value,
   input  wire logic          q_empty,
   input  wire logic          q_full,
   input  wire logic          back_busy,
   output logic               q_push,
   output xcpf_cmd_type       q_cmd,
   output logic               st_clear,
   output logic               st_wr_en,
   output logic [AW-1:0]      st_wr_addr,
   output logic [7:0]         st_wr_data
);

   logic [2:0]    header_count_ff, header_count_in;
   logic [FW-1:0] fill_count_ff, fill_count_in;
   logic [7:0]    frame_index_ff, frame_index_in;
   logic          data_sent_ff, data_sent_in;
   logic          data_phase_ff, data_phase_in;
   logic          pend_ff, pend_in;
   logic [7:0]    pend_value_ff, pend_value_in;

   logic          store_ok;
   logic          accept;
   logic [FW-1:0] fill_next;
   logic [7:0]    next_index;

   // The store may change only when no frame is waiting for or being read from it.
   assign store_ok   = !pend_ff && q_empty && !back_busy;
   assign fill_next  = fill_count_ff + 1'b1;
   assign next_index = data_sent_ff ? frame_index_ff + 8'd1 : 8'd0;

   always_comb begin
      unique case (req_kind)
         KIND_HEADER: req_ready = (header_count_ff == HEADER_MAX) ? 1'b1 : store_ok;
         KIND_IMAGE:  req_ready = store_ok;
         KIND_END:    req_ready = data_phase_ff ? (!pend_ff && !q_full) : 1'b1;
         default:     req_ready = 1'b1;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      header_count_in = header_count_ff;
      fill_count_in   = fill_count_ff;
      frame_index_in  = frame_index_ff;
      data_sent_in    = data_sent_ff;
      data_phase_in   = data_phase_ff;
      pend_in         = pend_ff;
      pend_value_in   = pend_value_ff;
      q_push          = 1'b0;
      q_cmd           = '{index: 8'd0, marker: MARK_START};
      st_clear        = 1'b0;
      st_wr_en        = 1'b0;
      st_wr_addr      = '0;
      st_wr_data      = req_value;

      // The first image byte goes into the store once the start frame is read out.
      if (pend_ff && q_empty && !back_busy) begin
         st_wr_en   = 1'b1;
         st_wr_addr = '0;
         st_wr_data = pend_value_ff;
         pend_in    = 1'b0;
      end

      if (accept) begin
         unique case (req_kind)
            KIND_HEADER: begin
               if (header_count_ff == 3'd0) begin
                  st_clear      = 1'b1;
                  data_phase_in = 1'b0;
                  fill_count_in = '0;
               end
               if (header_count_ff != HEADER_MAX) begin
                  st_wr_en        = 1'b1;
                  st_wr_addr      = AW'(header_count_ff);
                  header_count_in = header_count_ff + 3'd1;
               end
            end
            KIND_IMAGE: begin
               if (!data_phase_ff) begin
                  st_clear        = (header_count_ff == 3'd0);
                  q_push          = 1'b1;
                  q_cmd           = '{index: 8'd0, marker: MARK_START};
                  data_phase_in   = 1'b1;
                  header_count_in = 3'd0;
                  frame_index_in  = 8'd0;
                  data_sent_in    = 1'b0;
                  fill_count_in   = FW'(1);
                  pend_in         = 1'b1;
                  pend_value_in   = req_value;
               end else begin
                  st_wr_en   = 1'b1;
                  st_wr_addr = fill_count_ff[AW-1:0];
                  if (fill_next == FW'(PAYLOAD_BYTES)) begin
                     q_push         = 1'b1;
                     q_cmd          = '{index: next_index, marker: MARK_DATA};
                     frame_index_in = next_index;
                     data_sent_in   = 1'b1;
                     fill_count_in  = '0;
                  end else begin
                     fill_count_in = fill_next;
                  end
               end
            end
            KIND_END: begin
               header_count_in = 3'd0;
               if (data_phase_ff) begin
                  q_push        = 1'b1;
                  q_cmd         = '{index: frame_index_ff, marker: MARK_END};
                  data_phase_in = 1'b0;
                  fill_count_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= 3'd0;
         fill_count_ff   <= '0;
         frame_index_ff  <= 8'd0;
         data_sent_ff    <= 1'b0;
         data_phase_ff   <= 1'b0;
         pend_ff         <= 1'b0;
      end else begin
         header_count_ff <= header_count_in;
         fill_count_ff   <= fill_count_in;
         frame_index_ff  <= frame_index_in;
         data_sent_ff    <= data_sent_in;
         data_phase_ff   <= data_phase_in;
         pend_ff         <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
   end

endmodule

`default_nettype wire

### design/xcpf_back.sv
// Back end: takes frame commands from the queue, reads the payload store in order and
// sends payload, index, padding, marker and check byte. Depends on xcpf_pkg.
`default_nettype none

module xcpf_back
   import xcpf_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 32,
   parameter int CONTROL_BYTES = 3,
   localparam int FRAME_BYTES = PAYLOAD_BYTES + CONTROL_BYTES,
   localparam int AW = $clog2(PAYLOAD_BYTES),
   localparam int PW = $clog2(FRAME_BYTES)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_empty,
   input  wire xcpf_cmd_type  q_head,
   output logic               q_pop,
   output logic               busy,
   output logic               st_rd_en,
   output logic [AW-1:0]      st_rd_addr,
   input  wire logic [7:0]    st_rd_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_frame_last
);

   logic          busy_ff, busy_in;
   logic [PW-1:0] pos_ff, pos_in;
   xcpf_cmd_type  cur_ff, cur_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_pos_ff, s1_pos_in;
   logic [7:0]    xor_ff, xor_in;
   logic          advance;
   logic          s1_last;

   // Stage one holds the byte on the response port; it moves when empty or taken.
   assign advance = !s1_valid_ff || rsp_ready;
   assign q_pop   = !busy_ff && !q_empty;
   assign busy    = busy_ff;
   assign s1_last = (s1_pos_ff == PW'(FRAME_BYTES - 1));

   always_comb begin
      busy_in     = busy_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      s1_valid_in = s1_valid_ff;
      s1_pos_in   = s1_pos_ff;
      st_rd_en    = 1'b0;
      st_rd_addr  = pos_ff[AW-1:0];

      if (q_pop) begin
         busy_in = 1'b1;
         pos_in  = '0;
         cur_in  = q_head;
      end

      if (advance) begin
         s1_valid_in = busy_ff;
         if (busy_ff) begin
            s1_pos_in = pos_ff;
            st_rd_en  = (pos_ff < PW'(PAYLOAD_BYTES));
            if (pos_ff == PW'(FRAME_BYTES - 1)) begin
               busy_in = 1'b0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (s1_pos_ff < PW'(PAYLOAD_BYTES)) begin
         rsp_out_byte = st_rd_data;
      end else if (s1_pos_ff == PW'(PAYLOAD_BYTES)) begin
         rsp_out_byte = cur_ff.index;
      end else if (s1_pos_ff == PW'(FRAME_BYTES - 2)) begin
         rsp_out_byte = cur_ff.marker;
      end else if (s1_last) begin
         rsp_out_byte = xor_ff;
      end else begin
         rsp_out_byte = 8'h00;
      end
   end

   assign rsp_valid      = s1_valid_ff;
   assign rsp_frame_last = s1_last;

   // The check byte accumulates over sent bytes and restarts after each frame.
   always_comb begin
      xor_in = xor_ff;
      if (s1_valid_ff && rsp_ready) begin
         xor_in = s1_last ? 8'h00 : (xor_ff ^ rsp_out_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_pos_ff   <= '0;
         xor_ff      <= 8'h00;
      end else begin
         busy_ff     <= busy_in;
         pos_ff      <= pos_in;
         s1_valid_ff <= s1_valid_in;
         s1_pos_ff   <= s1_pos_in;
         xor_ff      <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

### design/xor_checked_packet_framer.sv
// Packet framer top level: front end, command queue, payload store and back end.
// A frame's PAYLOAD_BYTES + CONTROL_BYTES bytes leave at one per cycle while rsp_ready is high.
// Items that touch the payload store are stalled while a frame waits for or is read out of it; an
// end item that closes an image waits for room in the queue, and other items are taken one per
// cycle. Synchronous reset clears all control state; store entries read as zero until written,
// through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module xor_checked_packet_framer
   import xcpf_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 32,
   parameter int CONTROL_BYTES = 3
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_value,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_frame_last
);

   localparam int AW = $clog2(PAYLOAD_BYTES);

   logic         q_push, q_pop, q_empty, q_full, back_busy;
   xcpf_cmd_type q_cmd, q_head;
   logic         st_clear, st_wr_en, st_rd_en;
   logic [AW-1:0] st_wr_addr, st_rd_addr;
   logic [7:0]   st_wr_data, st_rd_data;

   xcpf_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .q_empty    (q_empty),
      .q_full     (q_full),
      .back_busy  (back_busy),
      .q_push     (q_push),
      .q_cmd      (q_cmd),
      .st_clear   (st_clear),
      .st_wr_en   (st_wr_en),
      .st_wr_addr (st_wr_addr),
      .st_wr_data (st_wr_data)
   );

   xcpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   xcpf_store #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (st_clear),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   xcpf_back #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .CONTROL_BYTES (CONTROL_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .busy           (back_busy),
      .st_rd_en       (st_rd_en),
      .st_rd_addr     (st_rd_addr),
      .st_rd_data     (st_rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

### bench/xcpf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the packet framer: watches both channels, predicts the framed byte stream
// and compares it with what the block sends. Depends on xcpf_pkg.

module xcpf_checker
   import xcpf_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 32,
   parameter int CONTROL_BYTES = 3
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_value,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_frame_last,
   output int              fail_count,
   output int              bytes_pending
);

   localparam int FRAME_BYTES = PAYLOAD_BYTES + CONTROL_BYTES;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_last;
   } framed_byte_type;

   logic [7:0]      payload [PAYLOAD_BYTES];
   logic [5:0]      fill_count;
   logic [2:0]      header_count;
   logic [7:0]      frame_index;
   logic [7:0]      check_byte;
   bit              imaging;
   bit              data_frame_sent;
   framed_byte_type framed_bytes [$];
   int              bytes_seen;

   function automatic void clear_payload();
      foreach (payload[i]) payload[i] = 8'h00;
   endfunction

   // Queues one whole frame from the payload as it stands now.
   function automatic void queue_frame(input logic [7:0] index, input logic [7:0] marker);
      logic [7:0] acc;
      logic [7:0] b;
      acc = 8'h00;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (i < PAYLOAD_BYTES) b = payload[i];
         else if (i == PAYLOAD_BYTES) b = index;
         else if (i == FRAME_BYTES - 2) b = marker;
         else if (i == FRAME_BYTES - 1) b = acc;
         else b = 8'h00;
         if (i != FRAME_BYTES - 1) acc ^= b;
         framed_bytes.push_back('{out_byte: b, frame_last: (i == FRAME_BYTES - 1)});
      end
      check_byte = acc;
   endfunction

   function automatic void frame_item(input logic [1:0] kind, input logic [7:0] value);
      case (kind)
         KIND_HEADER: begin
            // The first header byte starts a new image, dropping any image under way.
            if (header_count == 3'd0) begin
               clear_payload();
               imaging = 1'b0;
               fill_count = '0;
            end
            if (header_count < HEADER_MAX) begin
               payload[header_count] = value;
               header_count++;
            end
         end
         KIND_IMAGE: begin
            if (!imaging) begin
               if (header_count == 3'd0) clear_payload();
               queue_frame(8'h00, MARK_START);
               imaging = 1'b1;
               header_count = '0;
               frame_index = '0;
               data_frame_sent = 1'b0;
               fill_count = '0;
            end
            if (fill_count < PAYLOAD_BYTES) payload[fill_count] = value;
            fill_count = fill_count + 6'd1;
            if (fill_count >= PAYLOAD_BYTES) begin
               frame_index = data_frame_sent ? frame_index + 8'd1 : 8'd0;
               data_frame_sent = 1'b1;
               fill_count = '0;
               queue_frame(frame_index, MARK_DATA);
            end
         end
         KIND_END: begin
            if (imaging) begin
               queue_frame(frame_index, MARK_END);
               imaging = 1'b0;
               fill_count = '0;
            end
            header_count = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic void note_failure();
      fail_count++;
   endfunction

   always @(posedge clock) begin
      framed_byte_type want;
      if (reset) begin
         clear_payload();
         fill_count = '0;
         header_count = '0;
         frame_index = '0;
         check_byte = '0;
         imaging = 1'b0;
         data_frame_sent = 1'b0;
         framed_bytes.delete();
         bytes_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (framed_bytes.size() == 0) begin
               note_failure();
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: unexpected byte %02h last %b at output %0d",
                           $realtime, rsp_out_byte, rsp_frame_last, bytes_seen);
            end else begin
               want = framed_bytes.pop_front();
               if (want.out_byte !== rsp_out_byte || want.frame_last !== rsp_frame_last) begin
                  note_failure();
                  if (fail_count <= REPORT_LIMIT)
                     $display("%0t: output %0d expected byte %02h last %b, got byte %02h last %b",
                              $realtime, bytes_seen, want.out_byte, want.frame_last,
                              rsp_out_byte, rsp_frame_last);
               end
            end
            bytes_seen++;
         end
         if (req_valid && req_ready) frame_item(req_kind, req_value);
      end
      bytes_pending = framed_bytes.size();
   end

endmodule

### bench/tb_xor_checked_packet_framer.sv
`timescale 1ns / 1ps
// Top of the packet framer testbench: clock, reset, item stimulus and the verdict.
// Depends on xcpf_pkg, xor_checked_packet_framer and xcpf_checker.

module tb_xor_checked_packet_framer;
   import xcpf_pkg::*;

   localparam int         PAYLOAD_BYTES = 32;
   localparam int         CONTROL_BYTES = 3;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;
   localparam int         ITEM_TARGET   = 350;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         DRAIN_LIMIT   = 50000;
   localparam int         QUIET_CYCLES  = 100;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_kind = KIND_HEADER;
   logic [7:0] req_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_frame_last;
   int         fail_count;
   int         bytes_pending;
   int         items_sent = 0;
   bit         calm = 1'b0;
   bit         squeeze_req = 1'b0;
   bit         squeeze_done = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   xor_checked_packet_framer #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES),
      .CONTROL_BYTES(CONTROL_BYTES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_frame_last(rsp_frame_last)
   );

   xcpf_checker #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES),
      .CONTROL_BYTES(CONTROL_BYTES)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_frame_last(rsp_frame_last),
      .fail_count(fail_count),
      .bytes_pending(bytes_pending)
   );

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // Receiver: random stalls, none in calm stretches, and one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (squeeze_req && !squeeze_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            squeeze_done = 1'b1;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 20);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic offer(input logic [1:0] kind, input logic [7:0] value);
      while (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (bytes_pending != 0);
   endtask

   // One image: header bytes, image bytes with the odd stray item, then maybe an end item.
   task automatic send_image(input int headers, input int pixels, input bit finish,
                             input int noise);
      for (int i = 0; i < headers; i++) offer(KIND_HEADER, 8'($urandom));
      for (int i = 0; i < pixels; i++) begin
         if ($urandom_range(99) < noise) offer(2'($urandom_range(3)), 8'($urandom));
         offer(KIND_IMAGE, 8'($urandom));
      end
      if (finish) offer(KIND_END, 8'($urandom));
   endtask

   initial begin
      int burst;
      int pixels;
      int waited;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: end and unused kind while idle, start frame with no header, end before any
      // data frame, header overflow, and a header byte that aborts an image under way.
      offer(KIND_END, 8'h00);
      offer(KIND_UNUSED, 8'hFF);
      offer(KIND_IMAGE, 8'hFF);
      offer(KIND_END, 8'hFF);
      offer(KIND_HEADER, 8'hFF);
      offer(KIND_HEADER, 8'h00);
      offer(KIND_HEADER, 8'hA5);
      offer(KIND_HEADER, 8'h5A);
      offer(KIND_HEADER, 8'h01);
      offer(KIND_HEADER, 8'h80);
      offer(KIND_HEADER, 8'h7E);
      offer(KIND_IMAGE, 8'h00);
      offer(KIND_IMAGE, 8'h55);
      offer(KIND_HEADER, 8'h33);
      offer(KIND_IMAGE, 8'hAA);
      offer(KIND_END, 8'h12);
      offer(KIND_END, 8'hED);
      wait_drained();

      // The receiver holds off while items keep coming, so the block backs up.
      calm = 1'b1;
      squeeze_req = 1'b1;
      send_image(5, 6 * PAYLOAD_BYTES + 3, 1'b1, 0);
      calm = 1'b0;
      wait_drained();

      burst = 0;
      while (items_sent < ITEM_TARGET) begin
         calm = (burst % 8 == 3);
         if ($urandom_range(99) < 80) pixels = $urandom_range(1, 3 * PAYLOAD_BYTES);
         else pixels = $urandom_range(0, 8);
         send_image($urandom_range(7), pixels, $urandom_range(99) < 90, 5);
         if (burst % 5 == 4) wait_drained();
         burst++;
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (bytes_pending != 0 && waited < DRAIN_LIMIT);
      repeat (QUIET_CYCLES) @(negedge clock);
      if (fail_count == 0 && bytes_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
